// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, synchronous active-low reset disables
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pasm_pkg.sv =====
// ----------------------------------------------------------------------------
// pasm_pkg
// widths, mode codes and sequencer states of the polynomial add/sub/multiply
// ----------------------------------------------------------------------------
`default_nettype none

package pasm_pkg;

    localparam int DEG_W  = 4;
    localparam int RDEG_W = 5;
    localparam int COEF_W = 32;
    localparam int MODE_W = 2;

    // operation codes, the unused code behaves as sum
    localparam logic [MODE_W-1:0] MODE_SUM  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DIFF = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PROD = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SUM,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== sv/polynomial_add_sub_multiply.sv =====
// ----------------------------------------------------------------------------
// polynomial_add_sub_multiply
// loads coefficient pairs of two polynomials, then emits their sum, difference
// or schoolbook product one coefficient at a time through a shared adder
// and a single 32x32 multiplier
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                  payload
//   -------   ---------   ------------------------   --------------------------
//   in        to block    i_in_valid / o_in_stall    degree, coeff_a/b, last
//   out       from block  o_out_valid / i_out_stall  result_degree/coeff/last
//   cfg       to block    i_cfg_valid / o_cfg_ready  i_cfg_data (operation mode)
//
// loading accepts one item per cycle; the item marked last starts the result
// sum and difference: ST_SUM then ST_EMIT per coefficient, top+1 coefficients
// product: per coefficient, ST_MAC for i = 0..top (multiply-accumulate on the
//   shared multiplier and adder), ST_DRAIN, then ST_EMIT; 2*top+1 coefficients
// output stall holds the result register; input is stalled until the final
//   coefficient transfers, which also clears the stores (valid bits) at once
// reset is synchronous, active low; mode returns to sum, stores read as zero
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_add_sub_multiply #(
    parameter int MAX_TERMS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input item
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [pasm_pkg::DEG_W-1:0]    i_degree,
    input  wire logic signed [pasm_pkg::COEF_W-1:0] i_coeff_a,
    input  wire logic signed [pasm_pkg::COEF_W-1:0] i_coeff_b,
    input  wire logic                          i_last,
    // result item
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [pasm_pkg::RDEG_W-1:0]        o_result_degree,
    output logic signed [pasm_pkg::COEF_W-1:0] o_result_coeff,
    output logic                               o_result_last,
    // configuration
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pasm_pkg::MODE_W-1:0]   i_cfg_data
);
    import pasm_pkg::*;

    `include "assert_macros.svh"

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    // state
    t_state                  r_state, n_state;
    logic [MODE_W-1:0]       r_mode;
    logic [DEG_W-1:0]        r_top, n_top;
    logic [RDEG_W-1:0]       r_k, n_k;
    logic [DEG_W-1:0]        r_i, n_i;
    logic [COEF_W-1:0]       r_acc, n_acc;
    logic [COEF_W-1:0]       r_prod, n_prod;
    logic [COEF_W-1:0]       r_out_coeff, n_out_coeff;
    logic [MAX_TERMS-1:0]    r_vld, n_vld;
    logic [COEF_W-1:0]       r_a [MAX_TERMS];
    logic [COEF_W-1:0]       r_b [MAX_TERMS];

    logic                    w_is_prod, w_is_diff;
    logic                    w_deg_ok, w_wr_en;
    logic [RDEG_W-1:0]       w_deg_ext, w_i_ext, w_j, w_last_k;
    logic [AW-1:0]           w_wr_idx, w_a_idx, w_b_idx;
    logic [COEF_W-1:0]       w_a_rd, w_b_rd, w_mul_lo;
    logic                    w_term_ok, w_is_last;
    logic [COEF_W-1:0]       w_add_x, w_add_y, w_add_res;
    logic                    w_add_sub;

    assign w_is_prod = (r_mode == MODE_PROD);
    assign w_is_diff = (r_mode == MODE_DIFF);

    // load addressing
    assign w_deg_ext = {1'b0, i_degree};
    assign w_deg_ok  = (6'(i_degree) < 6'(MAX_TERMS));
    assign w_wr_idx  = w_deg_ext[AW-1:0];
    assign w_wr_en   = (r_state == ST_LOAD) && i_in_valid && w_deg_ok;

    // term indexes for the product: a[i] * b[k-i]
    assign w_i_ext   = {1'b0, r_i};
    assign w_j       = r_k - w_i_ext;
    assign w_term_ok = (w_i_ext <= r_k) && (w_j <= {1'b0, r_top});

    assign w_a_idx = (r_state == ST_SUM) ? r_k[AW-1:0] : w_i_ext[AW-1:0];
    assign w_b_idx = (r_state == ST_SUM) ? r_k[AW-1:0] : w_j[AW-1:0];

    // entries not written since the last clear read as zero
    assign w_a_rd = r_vld[w_a_idx] ? r_a[w_a_idx] : '0;
    assign w_b_rd = r_vld[w_b_idx] ? r_b[w_b_idx] : '0;

    // shared multiplier, low word only
    assign w_mul_lo = w_a_rd * w_b_rd;

    // shared adder
    always_comb begin
        if (r_state == ST_SUM) begin
            w_add_x   = w_a_rd;
            w_add_y   = w_b_rd;
            w_add_sub = w_is_diff;
        end else begin
            w_add_x   = r_acc;
            w_add_y   = r_prod;
            w_add_sub = 1'b0;
        end
    end
    assign w_add_res = w_add_sub ? (w_add_x - w_add_y) : (w_add_x + w_add_y);

    // final result degree
    assign w_last_k  = w_is_prod ? {r_top, 1'b0} : {1'b0, r_top};
    assign w_is_last = (r_k == w_last_k);

    // coefficient stores
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_a[w_wr_idx] <= i_coeff_a;
            r_b[w_wr_idx] <= i_coeff_b;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SUM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_top   <= '0;
            r_vld   <= '0;
            r_k     <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_vld   <= n_vld;
            r_k     <= n_k;
            r_i     <= n_i;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_prod      <= n_prod;
        r_out_coeff <= n_out_coeff;
    end

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_vld       = r_vld;
        n_k         = r_k;
        n_i         = r_i;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_out_coeff = r_out_coeff;
        unique case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    if (w_deg_ok) begin
                        n_vld[w_wr_idx] = 1'b1;
                        if (i_degree > r_top) begin
                            n_top = i_degree;
                        end
                    end
                    if (i_last) begin
                        n_k     = '0;
                        n_i     = '0;
                        n_acc   = '0;
                        n_prod  = '0;
                        n_state = w_is_prod ? ST_MAC : ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                n_out_coeff = w_add_res;
                n_state     = ST_EMIT;
            end
            ST_MAC: begin
                // accumulate the previous term while multiplying the next
                n_acc  = w_add_res;
                n_prod = w_term_ok ? w_mul_lo : '0;
                if (r_i == r_top) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_out_coeff = w_add_res;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_out_stall) begin
                    if (w_is_last) begin
                        n_vld   = '0;
                        n_top   = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_i     = '0;
                        n_acc   = '0;
                        n_prod  = '0;
                        n_state = w_is_prod ? ST_MAC : ST_SUM;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // ports
    assign o_in_stall      = (r_state != ST_LOAD);
    assign o_cfg_ready     = (r_state == ST_LOAD);
    assign o_out_valid     = (r_state == ST_EMIT);
    assign o_result_degree = r_k;
    assign o_result_coeff  = r_out_coeff;
    assign o_result_last   = w_is_last;

    // checks
    `ASSERT_IMPLIES(a_out_blocks_in, i_clk, i_rst_n, o_out_valid, o_in_stall && !o_cfg_ready, "input open while a result is pending")
    `ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_result_last, !o_in_stall && (r_vld == '0) && (r_top == '0), "stores not cleared after final transfer")
    `ASSERT_IMPLIES(a_mac_index, i_clk, i_rst_n, r_state == ST_MAC, (r_i <= r_top) && (r_k <= {r_top, 1'b0}), "product index beyond loaded degree")
    `ASSERT_IMPLIES(a_degree_bound, i_clk, i_rst_n, o_out_valid, o_result_degree <= w_last_k, "result degree past final coefficient")

endmodule

`default_nettype wire

// ===== sim/polynomial_add_sub_multiply_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_add_sub_multiply_test
// loads coefficient pairs, some extreme and some random, under every operation
// mode. A local predictor keeps its own coefficient stores and computes each
// sum, difference or wrapping schoolbook product. Every result transfer is
// checked against the oldest predicted coefficient. Both channels idle at
// random, and once the output is held off long enough to stall the input.
// ----------------------------------------------------------------------------
module polynomial_add_sub_multiply_test;
    import pasm_pkg::*;

    localparam int TERMS          = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    // spare mode code, expected to act as sum
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [RDEG_W-1:0] degree;
        logic [COEF_W-1:0] coeff;
        logic              last;
    } t_coeff_item;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [DEG_W-1:0]         i_degree = '0;
    logic [COEF_W-1:0]        i_coeff_a = '0;
    logic [COEF_W-1:0]        i_coeff_b = '0;
    logic                     i_last = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [RDEG_W-1:0]        o_result_degree;
    logic signed [COEF_W-1:0] o_result_coeff;
    logic                     o_result_last;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [MODE_W-1:0]        i_cfg_data = '0;

    // predictor state
    logic [COEF_W-1:0] a_terms [TERMS];
    logic [COEF_W-1:0] b_terms [TERMS];
    logic [DEG_W-1:0]  top_deg;
    logic [MODE_W-1:0] cur_mode;
    t_coeff_item       pending_coeffs [$];
    t_coeff_item       next_coeff;

    int  mismatch_count = 0;
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;

    polynomial_add_sub_multiply dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_degree        (i_degree),
        .i_coeff_a       (i_coeff_a),
        .i_coeff_b       (i_coeff_b),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_degree (o_result_degree),
        .o_result_coeff  (o_result_coeff),
        .o_result_last   (o_result_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // clear stores and top degree, as after each emitted result
    function automatic void clear_terms();
        for (int i = 0; i < TERMS; i++) begin
            a_terms[i] = '0;
            b_terms[i] = '0;
        end
        top_deg = '0;
    endfunction

    // store one accepted term and, on last, queue the full result
    task automatic absorb_term(input logic [DEG_W-1:0] deg, input logic [COEF_W-1:0] ca,
                               input logic [COEF_W-1:0] cb, input logic lst);
        int          count;
        int          top;
        logic [COEF_W-1:0] acc;
        t_coeff_item item;
        a_terms[deg] = ca;
        b_terms[deg] = cb;
        if (deg > top_deg)
            top_deg = deg;
        if (lst) begin
            top = int'(top_deg);
            count = (cur_mode == MODE_PROD) ? 2 * top + 1 : top + 1;
            for (int k = 0; k < count; k++) begin
                if (cur_mode == MODE_PROD) begin
                    acc = '0;
                    for (int i = 0; i <= top; i++) begin
                        if (i <= k && k - i <= top)
                            acc += a_terms[i] * b_terms[k - i];
                    end
                end else if (cur_mode == MODE_DIFF) begin
                    acc = a_terms[k] - b_terms[k];
                end else begin
                    acc = a_terms[k] + b_terms[k];
                end
                item.degree = RDEG_W'(k);
                item.coeff  = acc;
                item.last   = (k + 1 == count);
                pending_coeffs.push_back(item);
            end
            clear_terms();
        end
    endtask

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [COEF_W-1:0] rand_coeff();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            4: return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    // one input transfer; valid stays high for a back-to-back item
    task automatic send_term(input logic [DEG_W-1:0] deg, input logic [COEF_W-1:0] ca,
                             input logic [COEF_W-1:0] cb, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_degree   <= deg;
        i_coeff_a  <= ca;
        i_coeff_b  <= cb;
        i_last     <= lst;
        do @(posedge i_clk); while (o_in_stall);
        absorb_term(deg, ca, cb, lst);
        items_sent++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_coeffs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mode write, only once the block is idle
    task automatic set_mode(input logic [MODE_W-1:0] m);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    task automatic send_random_frame(input int max_deg);
        int n;
        n = $urandom_range(1, max_deg + 2);
        for (int j = 0; j < n; j++)
            send_term(DEG_W'($urandom_range(0, max_deg)), rand_coeff(), rand_coeff(),
                      j == n - 1);
    endtask

    // sum from reset mode, and a result with nothing loaded before it
    task automatic test_reset_mode();
        send_term(4'd0, 32'd5, 32'd7, 1'b1);
        send_term(4'd0, 32'd0, 32'd0, 1'b1);
    endtask

    task automatic test_sum_extremes();
        send_term(4'd15, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_term(4'd0,  32'h8000_0000, 32'h8000_0000, 1'b0);
        send_term(4'd7,  32'hffff_ffff, 32'h0000_0001, 1'b0);
        send_term(4'd3,  32'h1234_5678, 32'hedcb_a988, 1'b1);
    endtask

    // also a rewritten degree and a last below the top degree
    task automatic test_diff_extremes();
        set_mode(MODE_DIFF);
        send_term(4'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_term(4'd1, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_term(4'd4, 32'h0000_0000, 32'hffff_ffff, 1'b0);
        send_term(4'd1, 32'h0000_0005, 32'h0000_0003, 1'b0);
        send_term(4'd2, 32'h0000_0000, 32'h0000_0001, 1'b1);
    endtask

    task automatic test_product_extremes();
        set_mode(MODE_PROD);
        send_term(4'd0,  32'h8000_0000, 32'h8000_0000, 1'b0);
        send_term(4'd15, 32'hffff_ffff, 32'h7fff_ffff, 1'b0);
        send_term(4'd8,  32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        send_term(4'd0,  32'd3, 32'hffff_fffc, 1'b1);
    endtask

    task automatic test_spare_mode();
        set_mode(MODE_SPARE);
        send_term(4'd2, 32'h7fff_ffff, 32'h0000_0001, 1'b0);
        send_term(4'd0, 32'hffff_ffff, 32'h0000_0001, 1'b1);
    endtask

    task automatic test_random_sum();
        int goal;
        set_mode(MODE_SUM);
        goal = items_sent + 14;
        while (items_sent < goal)
            send_random_frame($urandom_range(0, 15));
    endtask

    // first half with no idling on either side
    task automatic test_random_diff();
        int goal;
        set_mode(MODE_DIFF);
        calm = 1'b1;
        goal = items_sent + 7;
        while (items_sent < goal)
            send_random_frame($urandom_range(0, 15));
        calm = 1'b0;
        goal = items_sent + 7;
        while (items_sent < goal)
            send_random_frame($urandom_range(0, 15));
    endtask

    task automatic test_random_product();
        int goal;
        set_mode(MODE_PROD);
        goal = items_sent + 18;
        while (items_sent < goal)
            send_random_frame($urandom_range(0, 4));
    endtask

    task automatic test_random_spare();
        int goal;
        set_mode(MODE_SPARE);
        goal = items_sent + 7;
        while (items_sent < goal)
            send_random_frame($urandom_range(0, 15));
    endtask

    // full-size products, top degree forced to the store limit
    task automatic test_wide_product();
        set_mode(MODE_PROD);
        repeat (2) begin
            send_term(4'd15, rand_coeff(), rand_coeff(), 1'b0);
            send_random_frame(15);
        end
    endtask

    // output held off while the sender keeps offering the next frame
    task automatic test_backpressure();
        set_mode(MODE_PROD);
        hold_req = 1'b1;
        wait (!hold_req);
        send_random_frame(6);
        send_term(4'd6, rand_coeff(), rand_coeff(), 1'b1);
        send_random_frame(5);
        send_term(4'd3, rand_coeff(), rand_coeff(), 1'b1);
    endtask

    // main sequence
    initial begin
        clear_terms();
        cur_mode = MODE_SUM;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_mode();
        test_sum_extremes();
        test_diff_extremes();
        test_product_extremes();
        test_spare_mode();
        test_random_sum();
        test_random_diff();
        test_random_product();
        test_random_spare();
        test_wide_product();
        test_backpressure();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver pacing, with the long hold-off on request
    initial begin
        int span;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (calm || $urandom_range(0, 2) != 0) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
                repeat (span) @(posedge i_clk);
            end
        end
    end

    // compare each result transfer with the oldest predicted coefficient
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_coeffs.size() == 0) begin
                $error("unexpected result: degree %0d coeff %h last %b",
                       o_result_degree, o_result_coeff, o_result_last);
                mismatch_count++;
            end else begin
                next_coeff = pending_coeffs.pop_front();
                if (o_result_degree !== next_coeff.degree) begin
                    $error("result_degree: expected %0d, actual %0d",
                           next_coeff.degree, o_result_degree);
                    mismatch_count++;
                end
                if (o_result_coeff !== next_coeff.coeff) begin
                    $error("result_coeff: expected %h, actual %h",
                           next_coeff.coeff, o_result_coeff);
                    mismatch_count++;
                end
                if (o_result_last !== next_coeff.last) begin
                    $error("result_last: expected %b, actual %b",
                           next_coeff.last, o_result_last);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
